// File: design/tgcs_pkg.sv
// shared types, constants and font table of the text glyph column streamer
`timescale 1ns / 1ps

package tgcs_pkg;

  // display geometry
  localparam int COLUMNS     = 128;
  localparam int LAST_PAGE   = 7;
  localparam int GLYPH_WIDTH = 5;

  // queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // input command codes
  localparam logic CMD_PRINT      = 1'b0;
  localparam logic CMD_SET_CURSOR = 1'b1;

  // character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7E;

  // display command bytes
  localparam logic [7:0] DISP_COL_ADDR  = 8'h21;
  localparam logic [7:0] DISP_PAGE_ADDR = 8'h22;
  localparam logic [7:0] BLANK_COLUMN   = 8'h00;

  localparam int FONT_ENTRIES = 95;

  // input transaction
  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [3:0] page;
    logic [7:0] column;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic       is_command;
    logic [7:0] payload;
    logic       last;
  } out_item_t;

  // job handed from the front to the back
  typedef struct packed {
    logic       set_cursor;
    logic [2:0] cs_page;
    logic [7:0] cs_column;
    logic       glyph;
    logic       printable;
    logic [6:0] glyph_idx;
  } job_t;

  // byte positions in the emitted sequence
  typedef enum logic [3:0] {
    ST_COL_CMD,
    ST_COL,
    ST_COL_END,
    ST_PAGE_CMD,
    ST_PAGE,
    ST_PAGE_END,
    ST_GLYPH0,
    ST_GLYPH1,
    ST_GLYPH2,
    ST_GLYPH3,
    ST_GLYPH4,
    ST_SPACER
  } step_e;

  // 5x8 font, leftmost column in the top byte
  localparam logic [39:0] FONT_ROM [FONT_ENTRIES] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  // one column byte of a glyph
  function automatic logic [7:0] font_column(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] entry;
    logic [2:0]  sh;
    entry = FONT_ROM[idx];
    sh    = 3'(GLYPH_WIDTH - 1) - col;
    return entry[{sh, 3'b000} +: 8];
  endfunction

endpackage

// File: design/text_glyph_column_streamer.sv
// top level of the text glyph column streamer
`timescale 1ns / 1ps

// Converts print and set-cursor transactions into a byte stream for a page-addressed
// display. The front accepts one transaction per cycle while the two-entry job queue
// has room and updates the text cursor at once; the back sequencer emits one byte
// per cycle into an output register while the receiver does not stall. An item
// produces 6 bytes for a character, a newline or an in-range set cursor, 12 for a
// character that wraps to the next page, and 0 for an out-of-range set cursor. The
// back sequencer's one-byte-per-cycle walk sets the sustained rate. The last flag marks
// the final byte of each item; command bytes carry is_command high.

module text_glyph_column_streamer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tgcs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tgcs_pkg::out_item_t out_item_o
);
  import tgcs_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  // classification and cursor
  tgcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  // job queue
  tgcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // byte sequencer
  tgcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: design/tgcs_front.sv
// front part: accepts items, keeps the cursor and turns items into jobs
`timescale 1ns / 1ps

module tgcs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tgcs_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tgcs_pkg::job_t   q_job_o
);
  import tgcs_pkg::*;

  logic [2:0] cursor_page_q, cursor_page_d;
  logic [7:0] cursor_col_q, cursor_col_d;

  logic       accept;
  logic       in_range;
  logic       newline;
  logic       at_edge;
  logic       wrap;
  logic       printable;
  logic [2:0] next_page;
  logic [7:0] base_col;
  logic [7:0] glyph_off;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // classification of the item against the current cursor
  always_comb begin
    in_range  = (in_item_i.page <= 4'(LAST_PAGE)) && ({1'b0, in_item_i.column} < 9'(COLUMNS));
    newline   = (in_item_i.char_code == CHAR_NEWLINE);
    at_edge   = ({1'b0, cursor_col_q} + 9'(GLYPH_WIDTH)) >= 9'(COLUMNS);
    wrap      = at_edge || newline;
    printable = (in_item_i.char_code >= CHAR_FIRST) && (in_item_i.char_code <= CHAR_LAST);
    next_page = (cursor_page_q >= 3'(LAST_PAGE)) ? 3'd0 : cursor_page_q + 3'd1;
    base_col  = wrap ? 8'd0 : cursor_col_q;
    glyph_off = newline ? 8'd0 : 8'(GLYPH_WIDTH + 1);
  end

  // job and cursor update
  always_comb begin
    q_job_o       = '0;
    q_push_o      = 1'b0;
    cursor_page_d = cursor_page_q;
    cursor_col_d  = cursor_col_q;
    if (in_item_i.command == CMD_SET_CURSOR) begin
      q_job_o.set_cursor = 1'b1;
      q_job_o.cs_page    = in_item_i.page[2:0];
      q_job_o.cs_column  = in_item_i.column;
      q_push_o           = accept && in_range;
      if (accept && in_range) begin
        cursor_page_d = in_item_i.page[2:0];
        cursor_col_d  = in_item_i.column;
      end
    end else begin
      q_job_o.set_cursor = wrap;
      q_job_o.cs_page    = next_page;
      q_job_o.cs_column  = 8'd0;
      q_job_o.glyph      = !newline;
      q_job_o.printable  = printable;
      q_job_o.glyph_idx  = printable ? 7'(in_item_i.char_code - CHAR_FIRST) : 7'd0;
      q_push_o           = accept;
      if (accept) begin
        if (wrap) begin
          cursor_page_d = next_page;
        end
        cursor_col_d = base_col + glyph_off;
      end
    end
  end

  // cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_page_q <= 3'd0;
      cursor_col_q  <= 8'd0;
    end else begin
      cursor_page_q <= cursor_page_d;
      cursor_col_q  <= cursor_col_d;
    end
  end

endmodule

// File: design/tgcs_queue.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps

module tgcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tgcs_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tgcs_pkg::job_t job_o
);
  import tgcs_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// File: design/tgcs_back.sv
// back part: walks each job one byte a cycle into the output register while the output is not stalled
`timescale 1ns / 1ps

module tgcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  tgcs_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tgcs_pkg::out_item_t out_item_o
);
  import tgcs_pkg::*;

  step_e     step_q, step_d;
  logic      active_q, active_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  step_e     start_step, end_step, cur_step;
  logic      advance;
  logic [7:0] byte_val;
  logic       byte_cmd;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequence bounds of the current job
  always_comb begin
    start_step = job_i.set_cursor ? ST_COL_CMD : ST_GLYPH0;
    end_step   = job_i.glyph ? ST_SPACER : ST_PAGE_END;
    cur_step   = active_q ? step_q : start_step;
    advance    = job_valid_i && (!out_valid_q || !out_stall_i);
  end

  // byte of the current step
  always_comb begin
    byte_cmd = 1'b1;
    byte_val = BLANK_COLUMN;
    unique case (cur_step)
      ST_COL_CMD:  byte_val = DISP_COL_ADDR;
      ST_COL:      byte_val = job_i.cs_column;
      ST_COL_END:  byte_val = 8'(COLUMNS - 1);
      ST_PAGE_CMD: byte_val = DISP_PAGE_ADDR;
      ST_PAGE:     byte_val = {5'd0, job_i.cs_page};
      ST_PAGE_END: byte_val = 8'(LAST_PAGE);
      ST_GLYPH0, ST_GLYPH1, ST_GLYPH2, ST_GLYPH3, ST_GLYPH4: begin
        byte_cmd = 1'b0;
        byte_val = job_i.printable
                 ? font_column(job_i.glyph_idx, 3'(cur_step - ST_GLYPH0)) : BLANK_COLUMN;
      end
      ST_SPACER: begin
        byte_cmd = 1'b0;
        byte_val = BLANK_COLUMN;
      end
      default: begin
        byte_cmd = 1'b1;
        byte_val = BLANK_COLUMN;
      end
    endcase
  end

  // sequencer and output register next state
  always_comb begin
    step_d      = step_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_pop_o   = 1'b0;
    if (advance) begin
      out_valid_d      = 1'b1;
      out_d.is_command = byte_cmd;
      out_d.payload    = byte_val;
      out_d.last       = (cur_step == end_step);
      if (cur_step == end_step) begin
        job_pop_o = 1'b1;
        active_d  = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = step_e'(cur_step + 4'd1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_COL_CMD;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // a job leaves the queue exactly with its final byte
  a_pop_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (out_valid_q && out_q.last))
    else $error("job popped without final byte");

  // a job without glyph never runs past the cursor bytes
  a_no_glyph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && job_valid_i && !job_i.glyph) |-> (step_q <= ST_PAGE_END))
    else $error("cursor-only job stepped into glyph bytes");

  // a held output byte is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output byte changed");

  // a new job starts only from an idle sequencer
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> !active_q)
    else $error("sequencer still active after job end");

endmodule

// File: sim/tb.sv
// self-checking testbench of the text glyph column streamer
`timescale 1ns / 1ps

module tb;
  import tgcs_pkg::*;

  // receiver stall behaviors
  typedef enum logic [1:0] {
    RX_FLOW,
    RX_RANDOM,
    RX_HEAVY
  } rx_mode_e;

  localparam int HALF_RANDOM      = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int LONG_HOLD_AFTER  = 600;
  localparam int DRAIN_CYCLES     = 20;

  // 5x8 font, leftmost column in the top byte
  localparam logic [39:0] GLYPHS [FONT_ENTRIES] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
    40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
    40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
    40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
    40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  text_glyph_column_streamer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // text cursor as the display sees it, and the bytes it must receive
  logic [2:0] cur_page = '0;
  logic [7:0] cur_col  = '0;
  out_item_t  predicted_bytes [$];
  in_item_t   queued_items [$];

  logic       item_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left   = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;
  rx_mode_e   rx_mode    = RX_FLOW;
  int         mode_left  = 0;
  int         bytes_seen = 0;
  int         errors     = 0;
  out_item_t  want;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void add_byte(logic is_cmd, logic [7:0] value);
    out_item_t b;
    b.is_command = is_cmd;
    b.payload    = value;
    b.last       = 1'b0;
    predicted_bytes.push_back(b);
  endfunction

  // cursor move: column range then page range
  function automatic void add_cursor_set(logic [2:0] pg, logic [7:0] col);
    cur_page = pg;
    cur_col  = col;
    add_byte(1'b1, DISP_COL_ADDR);
    add_byte(1'b1, col);
    add_byte(1'b1, 8'(COLUMNS - 1));
    add_byte(1'b1, DISP_PAGE_ADDR);
    add_byte(1'b1, {5'b0, pg});
    add_byte(1'b1, 8'(LAST_PAGE));
  endfunction

  function automatic void predict_bytes(in_item_t it);
    int          start;
    logic        printable;
    logic [39:0] glyph;
    out_item_t   tail;
    start = predicted_bytes.size();
    if (it.command == CMD_SET_CURSOR) begin
      // out-of-range targets are dropped silently
      if (it.page <= LAST_PAGE && it.column < COLUMNS) begin
        add_cursor_set(it.page[2:0], it.column);
      end
    end else begin
      // newline or a glyph that would hit the right edge moves to the next page
      if (int'(cur_col) + GLYPH_WIDTH >= COLUMNS || it.char_code == CHAR_NEWLINE) begin
        add_cursor_set((cur_page >= LAST_PAGE) ? 3'd0 : cur_page + 3'd1, 8'd0);
      end
      if (it.char_code != CHAR_NEWLINE) begin
        printable = it.char_code >= CHAR_FIRST && it.char_code <= CHAR_LAST;
        glyph     = printable ? GLYPHS[it.char_code - CHAR_FIRST] : '0;
        for (int i = 0; i < GLYPH_WIDTH; i++) begin
          add_byte(1'b0, glyph[39 - 8 * i -: 8]);
        end
        add_byte(1'b0, BLANK_COLUMN);
        cur_col = cur_col + 8'(GLYPH_WIDTH + 1);
      end
    end
    // flag the final byte of this transaction
    if (predicted_bytes.size() > start) begin
      tail      = predicted_bytes.pop_back();
      tail.last = 1'b1;
      predicted_bytes.push_back(tail);
    end
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [7:0] code, logic [3:0] pg,
                                         logic [7:0] col);
    in_item_t it;
    it.command   = cmd;
    it.char_code = code;
    it.page      = pg;
    it.column    = col;
    return it;
  endfunction

  // mostly printable text, with newlines, odd codes and cursor moves mixed in
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.command   = CMD_PRINT;
    it.char_code = 8'($urandom);
    it.page      = 4'($urandom);
    it.column    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.char_code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
    end else if (pick < 68) begin
      it.char_code = CHAR_NEWLINE;
    end else if (pick >= 92) begin
      it.command = CMD_SET_CURSOR;
    end else if (pick >= 76) begin
      it.command = CMD_SET_CURSOR;
      it.page    = 4'($urandom_range(0, LAST_PAGE));
      it.column  = $urandom_range(0, 1) ? 8'($urandom_range(COLUMNS - 28, COLUMNS - 1))
                                        : 8'($urandom_range(0, COLUMNS - 1));
    end
    return it;
  endfunction

  function automatic void queue_random(int count);
    in_item_t it;
    int       counted;
    counted = 0;
    while (counted < count) begin
      it = random_item();
      queued_items.push_back(it);
      if (!(it.command == CMD_SET_CURSOR && (it.page > LAST_PAGE || it.column >= COLUMNS))) begin
        counted++;
      end
    end
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (queued_items.size() != 0 || in_valid_i || predicted_bytes.size() != 0);
  endtask

  // record accepted transactions and predict their bytes
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_bytes(in_item_i);
    end
    item_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // sender: bursts of transactions separated by random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (queued_items.size() > 0) begin
        in_item_i  <= queued_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && bytes_seen >= LONG_HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FLOW:   out_stall_i <= 1'b0;
        RX_RANDOM: out_stall_i <= 1'($urandom_range(0, 1));
        default:   out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // compare each accepted byte with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_bytes.size() == 0) begin
        $error("unexpected byte: is_command %0b payload %02h last %0b",
               out_item_o.is_command, out_item_o.payload, out_item_o.last);
        errors++;
      end else begin
        want = predicted_bytes.pop_front();
        if (out_item_o.is_command !== want.is_command) begin
          $error("is_command: expected %0b, got %0b", want.is_command, out_item_o.is_command);
          errors++;
        end
        if (out_item_o.payload !== want.payload) begin
          $error("payload: expected %02h, got %02h", want.payload, out_item_o.payload);
          errors++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_item_o.last);
          errors++;
        end
        bytes_seen++;
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: glyph extremes, blanks, newline, edge wraps, rejected moves
    queued_items.push_back(make_item(CMD_PRINT, 8'h41, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, CHAR_FIRST, 4'd15, 8'd255));
    queued_items.push_back(make_item(CMD_PRINT, CHAR_LAST, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'h00, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'hFF, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'h1F, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'h7F, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, CHAR_NEWLINE, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'hFF, 4'(LAST_PAGE), 8'(COLUMNS - 1)));
    queued_items.push_back(make_item(CMD_PRINT, 8'h5A, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h00, 4'(LAST_PAGE + 1), 8'd0));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h00, 4'd15, 8'd255));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h00, 4'd0, 8'(COLUMNS)));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h41, 4'd3, 8'(COLUMNS - 6)));
    queued_items.push_back(make_item(CMD_PRINT, 8'h7B, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'h30, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h0A, 4'(LAST_PAGE), 8'(COLUMNS - 5)));
    queued_items.push_back(make_item(CMD_PRINT, CHAR_NEWLINE, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_SET_CURSOR, 8'h00, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, 8'h80, 4'd0, 8'd0));
    queued_items.push_back(make_item(CMD_PRINT, CHAR_NEWLINE, 4'd15, 8'd255));
    wait_drained();

    // random traffic in two halves with a full drain between them
    queue_random(HALF_RANDOM);
    wait_drained();
    queue_random(HALF_RANDOM);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0 && predicted_bytes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
